// File: rtl/rn_pkg.sv
// Package for the rank normaliser: capacity constants, the packed
// request, result, travelling-token and cell-slot types and the state enum.
// No dependencies.
package rn_pkg;

  localparam int MAX_COUNT = 64;
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [6:0] rank;
    logic       end_of_set;
    logic       overflowed;
  } out_t;

  // A newly loaded value travelling down the chain, counting stored
  // values that are less than or equal to it.
  typedef struct packed {
    logic               vld;
    logic signed [31:0] value;
    logic [CNT_W-1:0]   cnt;
  } tok_t;

  // The value parked in one cell and its running rank.
  typedef struct packed {
    logic               vld;
    logic signed [31:0] value;
    logic [CNT_W-1:0]   rank;
  } slot_t;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_DRAIN  = 3'b100
  } state_t;

endpackage

// File: rtl/rank_normalizer.sv
// Rank normaliser top level: load, settle and drain control around a
// chain of rn_cell instances.
// Depends on rn_pkg and rn_cell.
//
// Usage: signed 32-bit values arrive as requests on the in_ channel, one
// per cycle while in_ready is high. Each accepted value enters cell 0 as
// a token and moves one cell per cycle down the chain, comparing itself
// with every stored value on the way, until it parks in the first empty
// cell. Values beyond 64 in one set are dropped and the set is flagged
// as overflowed. A request marked last closes the set: in_ready falls,
// the block waits until every token has parked, then emits one result
// per stored value, in arrival order, one per cycle while out_ready is
// high, taken from cell 0 as the chain shifts towards it. A stall on
// out_ready simply holds the chain. After the final result in_ready
// rises again for the next set. Load throughput is one value per cycle
// while in_ready is high. Reset empties the chain and starts in the
// load phase.
module rank_normalizer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  rn_pkg::in_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output rn_pkg::out_t out_data
);

  rn_pkg::state_t             state_r, state_nxt;
  logic [rn_pkg::CNT_W-1:0]   fill_r, fill_nxt;
  logic [rn_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  logic                       ovf_r, ovf_nxt;

  rn_pkg::tok_t  tok_q [0:rn_pkg::MAX_COUNT];
  rn_pkg::slot_t slot_q [0:rn_pkg::MAX_COUNT];
  logic [rn_pkg::MAX_COUNT-1:0] tok_busy;

  logic in_acc;
  logic out_acc;
  logic full;
  logic shift;

  assign in_ready  = (state_r == rn_pkg::ST_LOAD);
  assign out_valid = (state_r == rn_pkg::ST_DRAIN);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign full      = (fill_r == rn_pkg::CNT_W'(rn_pkg::MAX_COUNT));
  assign shift     = out_acc;

  assign tok_q[0] = '{vld: in_acc && !full, value: in_data.value, cnt: '0};
  assign slot_q[rn_pkg::MAX_COUNT] = '0;

  for (genvar i = 0; i < rn_pkg::MAX_COUNT; i++) begin : g_cell
    rn_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok_q[i]),
      .shift    (shift),
      .slot_in  (slot_q[i+1]),
      .tok_out  (tok_q[i+1]),
      .slot_out (slot_q[i])
    );
    assign tok_busy[i] = tok_q[i+1].vld;
  end

  assign out_data.rank       = slot_q[0].rank;
  assign out_data.end_of_set = (rem_r == rn_pkg::CNT_W'(1));
  assign out_data.overflowed = ovf_r;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    rem_nxt   = rem_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      rn_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
          if (in_data.last) begin
            state_nxt = rn_pkg::ST_SETTLE;
          end
        end
      end
      rn_pkg::ST_SETTLE: begin
        if (tok_busy == '0) begin
          rem_nxt   = fill_r;
          state_nxt = rn_pkg::ST_DRAIN;
        end
      end
      rn_pkg::ST_DRAIN: begin
        if (out_acc) begin
          rem_nxt = rem_r - 1'b1;
          if (rem_r == rn_pkg::CNT_W'(1)) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = rn_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = rn_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rn_pkg::ST_LOAD;
      fill_r  <= '0;
      rem_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rem_r   <= rem_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// File: rtl/rn_cell.sv
// One cell of the rank chain: holds one stored value with its rank, passes
// the travelling token on to the next cell and takes the next slot on a shift.
// Depends on rn_pkg.
module rn_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  rn_pkg::tok_t  tok_in,
  input  logic          shift,
  input  rn_pkg::slot_t slot_in,
  output rn_pkg::tok_t  tok_out,
  output rn_pkg::slot_t slot_out
);

  rn_pkg::slot_t slot_r, slot_nxt;
  rn_pkg::tok_t  tok_r, tok_nxt;
  logic          s_le_v;
  logic          v_le_s;

  assign s_le_v = slot_r.value <= tok_in.value;
  assign v_le_s = tok_in.value <= slot_r.value;

  always_comb begin
    slot_nxt = slot_r;
    tok_nxt  = tok_in;
    tok_nxt.vld = 1'b0;
    if (shift) begin
      slot_nxt = slot_in;
    end else if (tok_in.vld) begin
      if (slot_r.vld) begin
        // Pass the token on, both sides counting their own rank.
        tok_nxt.vld = 1'b1;
        if (s_le_v) begin
          tok_nxt.cnt = tok_in.cnt + 1'b1;
        end
        if (v_le_s) begin
          slot_nxt.rank = slot_r.rank + 1'b1;
        end
      end else begin
        // First empty cell: the token settles here, counting itself.
        slot_nxt.vld   = 1'b1;
        slot_nxt.value = tok_in.value;
        slot_nxt.rank  = tok_in.cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
      tok_r.vld  <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_out  = tok_r;
  assign slot_out = slot_r;

endmodule
